// ----- rtl/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, skipped while reset is high
`define SLLM_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sllm assertion failed");

// property checked at every rising edge, reset included
`define SLLM_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sllm assertion failed");

`endif

// ----- rtl/sllm_pkg.sv -----
// slot linked list manager: sizes, codes and slot helpers
// used by the top level and the checker, no dependencies
`default_nettype none

package sllm_pkg;

   localparam int MAX_SLOTS  = 64;
   localparam int VALUE_BITS = 32;

   localparam int ADDR_BITS  = $clog2(MAX_SLOTS);
   // one extra bit so the all-ones none marker never names a real slot
   localparam int LINK_BITS  = ADDR_BITS + 1;
   localparam int CAP_BITS   = 7;
   localparam int CNT_BITS   = $clog2(MAX_SLOTS + 1);
   localparam int SCAN_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   localparam int NEXT_LSB      = VALUE_BITS;
   localparam int POS_LSB       = VALUE_BITS + LINK_BITS;
   localparam int RSP_USED_BITS = VALUE_BITS + LINK_BITS + ADDR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

   localparam logic [LINK_BITS-1:0] NONE_SLOT = '1;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_BITS-1:0] OP_NOP    = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd3;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [LINK_BITS-1:0]  link_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;

   function automatic logic slot_ok(input link_type s);
      slot_ok = (s < LINK_BITS'(MAX_SLOTS));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sllm_ram.sv -----
// generic simple dual-port ram: one write and one registered read per cycle
// no dependencies
`default_nettype none

module sllm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/slot_linked_list_manager.sv -----
// slot linked list manager top level: control sequencer, slot flags, head and tail
// depends on sllm_pkg and sllm_ram
//
// req channel: tuser carries the operation (insert, remove, middle query, nop), tdata the
// value. one request is taken at a time; req_tready is high only while idle.
// rsp channel: exactly one result per request, tuser carries the status, tdata the
// query value, next link and slot position (zero unless a query succeeds). the
// result sits in an output register, so a new request is taken while an earlier
// result still waits on a stalled receiver; a second finished result holds in the
// sequencer, which stalls the request side until the output register frees.
// csr channel: capacity write, always ready. the user makes a capacity write only while
// the block is idle; the block itself does not enforce this. capacity saturates at 64.
// query scans the run of occupied slots from slot 0, then reads its middle slot;
// insert scans for the first free slot, writes it, then links it after a nonempty tail,
// or reports full when the scan reaches the capacity;
// remove walks from the head, one ram read per element visited (at most 64 elements).
// the sequencer takes the next request in the cycle after the result is loaded.
// reset: empty list, capacity 64, no result pending. values and links live in
// two rams that need no clearing since only occupied slots are ever read.
`default_nettype none

module slot_linked_list_manager (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [sllm_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // value
   input  wire logic [sllm_pkg::OP_BITS-1:0]         req_tuser,  // operation
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [sllm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // found_value, found_next,
                                                                 // position, zero pad
   output logic      [sllm_pkg::STATUS_BITS-1:0]     rsp_tuser,  // status
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sllm_pkg::CAP_BITS-1:0]        csr_wdata   // capacity_in_use
);

   import sllm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_INS   = 3'd2;
   localparam logic [2:0] S_LINK  = 3'd3;
   localparam logic [2:0] S_QRD   = 3'd4;
   localparam logic [2:0] S_QDATA = 3'd5;
   localparam logic [2:0] S_WALK  = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   value_type              value_ff, value_in;
   logic [CAP_BITS-1:0]    cap_ff, cap_in;
   logic [MAX_SLOTS-1:0]   used_ff, used_in;
   link_type               head_ff, head_in;
   link_type               tail_ff, tail_in;
   logic [SCAN_BITS-1:0]   scan_ff, scan_in;
   addr_type               slot_ff, slot_in;
   link_type               prev_ff, prev_in;
   addr_type               steps_ff, steps_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   value_type              res_value_ff, res_value_in;
   link_type               res_next_ff, res_next_in;
   addr_type               res_pos_ff, res_pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   value_type              rsp_value_ff, rsp_value_in;
   link_type               rsp_next_ff, rsp_next_in;
   addr_type               rsp_pos_ff, rsp_pos_in;

   logic [SCAN_BITS-1:0]   cap_eff;
   logic                   scan_done;
   logic                   req_xfer;
   logic                   fin_load;

   logic                   val_wr_en;
   logic                   link_wr_en;
   addr_type               link_wr_addr;
   link_type               link_wr_data;
   logic                   rd_en;
   addr_type               rd_addr;
   value_type              val_rd;
   link_type               link_rd;

   sllm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_SLOTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (slot_ff),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   sllm_ram #(.WIDTH(LINK_BITS), .DEPTH(MAX_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   // capacity above the table size saturates
   assign cap_eff = (SCAN_BITS'(cap_ff) > SCAN_BITS'(MAX_SLOTS)) ?
                    SCAN_BITS'(MAX_SLOTS) : SCAN_BITS'(cap_ff);

   // stops at the first free slot or at the capacity
   assign scan_done = (scan_ff == cap_eff) || !used_ff[scan_ff[ADDR_BITS-1:0]];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign fin_load   = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_pos_ff, rsp_next_ff, rsp_value_ff});

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      cap_in        = cap_ff;
      used_in       = used_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      scan_in       = scan_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_next_in   = res_next_ff;
      res_pos_in    = res_pos_ff;
      val_wr_en     = 1'b0;
      link_wr_en    = 1'b0;
      link_wr_addr  = slot_ff;
      link_wr_data  = NONE_SLOT;
      rd_en         = 1'b0;
      rd_addr       = slot_ff;

      if (csr_valid && csr_ready) begin
         cap_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            res_status_in = ST_OK;
            res_value_in  = '0;
            res_next_in   = '0;
            res_pos_in    = '0;
            if (req_xfer) begin
               op_in    = req_tuser;
               value_in = req_tdata[VALUE_BITS-1:0];
               scan_in  = '0;
               unique case (req_tuser)
                  OP_INSERT, OP_QUERY: state_in = S_SCAN;
                  OP_REMOVE: begin
                     if (slot_ok(head_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff[ADDR_BITS-1:0];
                        slot_in  = head_ff[ADDR_BITS-1:0];
                        prev_in  = NONE_SLOT;
                        steps_in = '0;
                        state_in = S_WALK;
                     end else begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_FIN;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end

         S_SCAN: begin
            if (scan_done) begin
               if (op_ff == OP_INSERT) begin
                  if (scan_ff == cap_eff) begin
                     res_status_in = ST_FULL;
                     state_in      = S_FIN;
                  end else begin
                     slot_in  = scan_ff[ADDR_BITS-1:0];
                     state_in = S_INS;
                  end
               end else if (scan_ff == '0) begin
                  res_status_in = ST_EMPTY;
                  state_in      = S_FIN;
               end else begin
                  // one or two occupied slots report slot 0, else count/2
                  slot_in  = (scan_ff <= SCAN_BITS'(2)) ? '0 :
                             ADDR_BITS'(scan_ff >> 1);
                  state_in = S_QRD;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         S_INS: begin
            val_wr_en           = 1'b1;
            link_wr_en          = 1'b1;
            used_in[slot_ff]    = 1'b1;
            res_status_in       = ST_OK;
            if (!slot_ok(head_ff)) begin
               head_in  = {1'b0, slot_ff};
               tail_in  = {1'b0, slot_ff};
               state_in = S_FIN;
            end else if (slot_ok(tail_ff)) begin
               state_in = S_LINK;
            end else begin
               tail_in  = {1'b0, slot_ff};
               state_in = S_FIN;
            end
         end

         S_LINK: begin
            link_wr_en   = 1'b1;
            link_wr_addr = tail_ff[ADDR_BITS-1:0];
            link_wr_data = {1'b0, slot_ff};
            tail_in      = {1'b0, slot_ff};
            state_in     = S_FIN;
         end

         S_QRD: begin
            rd_en    = 1'b1;
            state_in = S_QDATA;
         end

         S_QDATA: begin
            res_status_in = ST_OK;
            res_value_in  = val_rd;
            res_next_in   = link_rd;
            res_pos_in    = slot_ff;
            state_in      = S_FIN;
         end

         S_WALK: begin
            // ram output holds value and link of the slot in slot_ff
            if (val_rd == value_ff) begin
               used_in[slot_ff] = 1'b0;
               res_status_in    = ST_OK;
               state_in         = S_FIN;
               if (!slot_ok(prev_ff)) begin
                  if (slot_ok(link_rd)) begin
                     head_in = link_rd;
                  end else begin
                     head_in = NONE_SLOT;
                     tail_in = NONE_SLOT;
                  end
               end else begin
                  link_wr_en   = 1'b1;
                  link_wr_addr = prev_ff[ADDR_BITS-1:0];
                  link_wr_data = link_rd;
                  if (tail_ff == {1'b0, slot_ff}) begin
                     tail_in = prev_ff;
                  end
               end
            end else if (slot_ok(link_rd) && (steps_ff != ADDR_BITS'(MAX_SLOTS - 1))) begin
               // follow the link straight from the ram output
               rd_en    = 1'b1;
               rd_addr  = link_rd[ADDR_BITS-1:0];
               prev_in  = {1'b0, slot_ff};
               slot_in  = link_rd[ADDR_BITS-1:0];
               steps_in = steps_ff + 1'b1;
            end else begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_FIN;
            end
         end

         S_FIN: begin
            if (fin_load) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_pos_in    = rsp_pos_ff;
      if (fin_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
         rsp_next_in   = res_next_ff;
         rsp_pos_in    = res_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_BITS'(64);
         used_ff      <= '0;
         head_ff      <= NONE_SLOT;
         tail_ff      <= NONE_SLOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         used_ff      <= used_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      scan_ff       <= scan_in;
      slot_ff       <= slot_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_next_ff   <= res_next_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

endmodule

`default_nettype wire

// ----- rtl/sllm_checker.sv -----
// port-level checks for the slot linked list manager, bound to the top level
// depends on sllm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sllm_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [sllm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input wire logic [sllm_pkg::STATUS_BITS-1:0]    rsp_tuser
);

   import sllm_pkg::*;

   logic next_is_none;
   logic next_in_range;
   logic rsp_wait;
   logic rsp_ok;
   logic rsp_fail;
   logic req_xfer;
   logic [STATUS_BITS+RSP_DATA_BITS-1:0] rsp_bits;

   assign next_is_none  = (rsp_tdata[POS_LSB-1:NEXT_LSB] == NONE_SLOT);
   assign next_in_range = (rsp_tdata[POS_LSB-1:NEXT_LSB] < LINK_BITS'(MAX_SLOTS));
   assign rsp_wait      = rsp_tvalid && !rsp_tready;
   assign rsp_ok        = rsp_tvalid && (rsp_tuser == ST_OK);
   assign rsp_fail      = rsp_tvalid && (rsp_tuser != ST_OK);
   assign req_xfer      = req_tvalid && req_tready;
   assign rsp_bits      = {rsp_tuser, rsp_tdata};

   // a stalled result keeps its content
   `SLLM_ASSERT_RST(a_rsp_hold, clock, reset, rsp_wait |=> rsp_tvalid && $stable(rsp_bits))

   // only a successful query carries data
   `SLLM_ASSERT_RST(a_fail_zero, clock, reset, rsp_fail |-> (rsp_tdata == '0))

   // a successful result links to a real slot or to none
   `SLLM_ASSERT_RST(a_next_valid, clock, reset, rsp_ok |-> next_is_none || next_in_range)

   // one request at a time: busy right after a request transfer
   `SLLM_ASSERT_RST(a_busy_after_req, clock, reset, req_xfer |=> !req_tready)

   // reset leaves no result pending
   `SLLM_ASSERT(a_reset_clear, clock, reset |=> !rsp_tvalid)

endmodule

bind slot_linked_list_manager sllm_checker u_sllm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- tb/slot_linked_list_manager_tb.sv -----
// testbench for the slot linked list manager: directed and random list operations,
// predicted by an in-bench list model and checked per result transfer
// depends on sllm_pkg and the slot_linked_list_manager rtl
`default_nettype none

module slot_linked_list_manager_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sllm_pkg::*;

   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 80;
   localparam int RANDOM_ITEMS  = 1480;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      value_type              found_value;
      link_type               found_next;
      addr_type               position;
   } list_result_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [OP_BITS-1:0]       req_tuser  = OP_NOP;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CAP_BITS-1:0]      csr_wdata  = '0;

   // list model state, links as int with -1 for none
   value_type           slot_val [MAX_SLOTS];
   int                  slot_nxt [MAX_SLOTS];
   bit                  slot_busy[MAX_SLOTS];
   int                  head_idx;
   int                  tail_idx;
   logic [CAP_BITS-1:0] cap_reg;

   list_result_type results_due[$];
   int              fail_count = 0;
   bit              no_idle    = 1'b0;
   int              sink_hold  = 0;

   slot_linked_list_manager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic list_result_type predict_list_op(input logic [OP_BITS-1:0] op,
                                                        input value_type val);
      list_result_type r;
      int lim, i, prev, cur, steps, cnt, mid;
      r = '0;
      lim = (cap_reg > MAX_SLOTS) ? MAX_SLOTS : int'(cap_reg);
      case (op)
         OP_INSERT: begin
            i = 0;
            while (i < lim && slot_busy[i]) i++;
            if (i == lim) begin
               r.status = ST_FULL;
            end else begin
               slot_busy[i] = 1'b1;
               slot_val[i]  = val;
               slot_nxt[i]  = -1;
               if (head_idx < 0) head_idx = i;
               else if (tail_idx >= 0) slot_nxt[tail_idx] = i;
               tail_idx = i;
            end
         end
         OP_REMOVE: begin
            prev  = -1;
            cur   = head_idx;
            steps = 0;
            while (cur >= 0 && cur < MAX_SLOTS && steps < MAX_SLOTS && slot_val[cur] != val) begin
               prev = cur;
               cur  = slot_nxt[cur];
               steps++;
            end
            if (cur < 0 || cur >= MAX_SLOTS || steps >= MAX_SLOTS) begin
               r.status = ST_NOT_FOUND;
            end else begin
               if (prev < 0) begin
                  head_idx = slot_nxt[cur];
                  if (head_idx < 0) begin
                     head_idx = -1;
                     tail_idx = -1;
                  end
               end else begin
                  slot_nxt[prev] = slot_nxt[cur];
                  // removing the tail moves it back one element
                  if (tail_idx == cur) tail_idx = prev;
               end
               slot_busy[cur] = 1'b0;
               slot_val[cur]  = '0;
               slot_nxt[cur]  = 0;
            end
         end
         OP_QUERY: begin
            cnt = 0;
            while (cnt < lim && slot_busy[cnt]) cnt++;
            if (cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               mid = (cnt <= 2) ? 0 : cnt / 2;
               r.found_value = slot_val[mid];
               r.found_next  = link_type'(slot_nxt[mid]);
               r.position    = addr_type'(mid);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic value_type random_value();
      // small pool half the time so duplicates and matches are common
      if ($urandom_range(0, 1) != 0) return $urandom;
      return value_type'($urandom_range(0, 7) - 4);
   endfunction

   function automatic value_type pick_stored_value();
      int idx[$];
      for (int i = 0; i < MAX_SLOTS; i++)
         if (slot_busy[i]) idx.push_back(i);
      if (idx.size() == 0) return $urandom;
      return slot_val[idx[$urandom_range(0, idx.size() - 1)]];
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      fail_count++;
      $display("mismatch %s: expected %h got %h", what, want, got);
   endtask

   task automatic send_item(input logic [OP_BITS-1:0] op, input value_type val);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_BITS'(val);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      results_due.push_back(predict_list_op(op, val));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
      wait_drain();
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cap_reg = cap;
      csr_valid <= 1'b0;
   endtask

   task automatic empty_list();
      while (head_idx >= 0) send_item(OP_REMOVE, slot_val[head_idx]);
   endtask

   task automatic test_directed_basics();
      send_item(OP_QUERY, '0);
      send_item(OP_REMOVE, '0);
      send_item(OP_NOP, '1);
      send_item(OP_INSERT, 32'h8000_0000);
      send_item(OP_INSERT, 32'h7fff_ffff);
      send_item(OP_INSERT, 32'h0000_0000);
      send_item(OP_INSERT, 32'hffff_ffff);
      send_item(OP_QUERY, '0);
      // tail removal, then an insert must link after the new tail
      send_item(OP_REMOVE, 32'hffff_ffff);
      send_item(OP_INSERT, 32'd5);
      send_item(OP_QUERY, '0);
      // head removal frees slot 0, so the query sees an empty run
      send_item(OP_REMOVE, 32'h8000_0000);
      send_item(OP_QUERY, '0);
      send_item(OP_INSERT, 32'd5);
      send_item(OP_REMOVE, 32'd5);
      send_item(OP_REMOVE, 32'd12345);
      empty_list();
   endtask

   task automatic test_capacity_extremes();
      set_capacity(7'd1);
      send_item(OP_INSERT, 32'h1234_5678);
      send_item(OP_INSERT, 32'h0bad_cafe);
      send_item(OP_QUERY, '0);
      set_capacity(7'd0);
      send_item(OP_INSERT, 32'd1);
      send_item(OP_QUERY, '0);
      send_item(OP_REMOVE, 32'h1234_5678);
      set_capacity(7'd127);
      send_item(OP_INSERT, 32'd9);
      send_item(OP_QUERY, '0);
      empty_list();
   endtask

   task automatic test_capacity_shrink();
      set_capacity(7'd64);
      for (int i = 0; i < 6; i++) send_item(OP_INSERT, value_type'(100 + i));
      // slots at or above the new capacity stay linked and removable
      set_capacity(7'd3);
      send_item(OP_QUERY, '0);
      send_item(OP_INSERT, 32'd200);
      send_item(OP_REMOVE, 32'd105);
      send_item(OP_QUERY, '0);
      set_capacity(7'd64);
      empty_list();
   endtask

   task automatic test_stall_pressure();
      set_capacity(7'd8);
      no_idle   = 1'b1;
      sink_hold = HOLD_CYCLES;
      for (int i = 0; i < 10; i++)
         send_item(($urandom_range(0, 2) != 0) ? OP_INSERT : OP_QUERY, random_value());
      no_idle = 1'b0;
      // sender waits for every result before going on
      wait_drain();
      for (int i = 0; i < 6; i++) send_item(OP_REMOVE, pick_stored_value());
      wait_drain();
   endtask

   task automatic test_random_traffic();
      int                  fixed_caps[6];
      int                  sent, phase, n, r;
      logic [CAP_BITS-1:0] cap;
      fixed_caps = '{64, 1, 2, 127, 0, 3};
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < 6) begin
            cap = CAP_BITS'(fixed_caps[phase]);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) cap = CAP_BITS'($urandom_range(1, 10));
            else if (r < 90) cap = CAP_BITS'($urandom_range(11, 64));
            else cap = CAP_BITS'($urandom_range(65, 127));
         end
         set_capacity(cap);
         no_idle = (phase % 4 == 2);
         n = (cap == 0) ? 20 : $urandom_range(60, 140);
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40)
               send_item(OP_INSERT, random_value());
            else if (r < 75)
               send_item(OP_REMOVE, ($urandom_range(0, 3) != 0) ? pick_stored_value()
                                                                : random_value());
            else if (r < 95)
               send_item(OP_QUERY, $urandom);
            else
               send_item(OP_NOP, $urandom);
         end
         sent += n;
         phase++;
      end
      no_idle = 1'b0;
   endtask

   // result receiver, its own stall counter; a hold request overrides random stalls
   initial begin : result_sink
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (sink_hold > 0) begin
            stall     = sink_hold;
            sink_hold = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!no_idle) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : result_check
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tuser;
         got.found_value = rsp_tdata[VALUE_BITS-1:0];
         got.found_next  = rsp_tdata[NEXT_LSB +: LINK_BITS];
         got.position    = rsp_tdata[POS_LSB +: ADDR_BITS];
         if (results_due.size() == 0) begin
            note_mismatch("result transfer with nothing pending", '0, 64'(got));
         end else begin
            want = results_due.pop_front();
            if (got.status !== want.status)
               note_mismatch("status", 64'(want.status), 64'(got.status));
            if (got.found_value !== want.found_value)
               note_mismatch("found_value", 64'(want.found_value), 64'(got.found_value));
            if (got.found_next !== want.found_next)
               note_mismatch("found_next", 64'(want.found_next), 64'(got.found_next));
            if (got.position !== want.position)
               note_mismatch("position", 64'(want.position), 64'(got.position));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : main_seq
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_val[i]  = '0;
         slot_nxt[i]  = 0;
         slot_busy[i] = 1'b0;
      end
      head_idx = -1;
      tail_idx = -1;
      cap_reg  = 7'd64;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_capacity_extremes();
      test_capacity_shrink();
      test_stall_pressure();
      test_random_traffic();
      wait_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
